### hw/rtl/rgb_led_matrix_pwm_scanner_top_defines.svh
// Assertion macros used by rlps_checker for its concurrent checks.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef RGB_LED_MATRIX_PWM_SCANNER_TOP_DEFINES_SVH
`define RGB_LED_MATRIX_PWM_SCANNER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rlps_pkg.sv
// Package of the RGB LED matrix PWM scanner: sizes, item codes and the
// command and status types between controller and datapath. No dependencies.
`default_nettype none

package rlps_pkg;

  localparam int ROWS    = 8;
  localparam int PIXELS  = 64;
  localparam int COLS    = PIXELS / ROWS;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLS);
  localparam int IDX_W   = $clog2(PIXELS);
  localparam int CNT_W   = $clog2(ROWS + 1);
  localparam int LEVEL_W = 8;
  localparam int PIXEL_W = 3 * LEVEL_W;
  localparam int KIND_W  = 2;

  localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 8'hFF;
  localparam logic [COLS-1:0]    BLANK_BITS   = 8'hFF;
  localparam logic [ROWS-1:0]    BLANK_ROWS   = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic             wr_en;
    logic             clr_en;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             load_row;
    logic             load_blank;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/rlps_channels_if.sv
// Handshake channels of the scanner: pixel, tick and clear items in, row results out,
// and the brightness register write port. Depends on rlps_pkg.
`default_nettype none

interface rlps_in_if;
  logic                              valid;
  logic                              ready;
  logic [rlps_pkg::KIND_W-1:0]       kind;
  logic [rlps_pkg::IDX_W-1:0]        pixel_index;
  logic [rlps_pkg::LEVEL_W-1:0]      red_level;
  logic [rlps_pkg::LEVEL_W-1:0]      green_level;
  logic [rlps_pkg::LEVEL_W-1:0]      blue_level;

  modport source (output valid, kind, pixel_index, red_level, green_level, blue_level,
                  input ready);
  modport sink (input valid, kind, pixel_index, red_level, green_level, blue_level,
                output ready);
endinterface

interface rlps_out_if;
  logic                         valid;
  logic                         ready;
  logic [rlps_pkg::ROWS-1:0]    row_select;
  logic [rlps_pkg::COLS-1:0]    green_bits;
  logic [rlps_pkg::COLS-1:0]    red_bits;
  logic [rlps_pkg::COLS-1:0]    blue_bits;
  logic                         last;

  modport source (output valid, row_select, green_bits, red_bits, blue_bits, last,
                  input ready);
  modport sink (input valid, row_select, green_bits, red_bits, blue_bits, last,
                output ready);
endinterface

interface rlps_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rlps_pkg::LEVEL_W-1:0] brightness_top;

  modport source (output valid, brightness_top, input ready);
  modport sink (input valid, brightness_top, output ready);
endinterface

`default_nettype wire

### hw/rtl/rlps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rlps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rlps_ctrl.sv
// Controller of the scanner: accepts items and sequences the row reads and
// result loads of a tick. Depends on rlps_pkg.
`default_nettype none

module rlps_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [rlps_pkg::KIND_W-1:0] in_kind,
  output logic                             in_ready,
  input  wire rlps_pkg::dp_status_t        status,
  output rlps_pkg::dp_cmd_t                cmd
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                      state_r, state_nxt;
  logic [rlps_pkg::CNT_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic                        pend_r, pend_nxt;
  logic                        rows_done;

  assign rows_done = (rd_cnt_r == rlps_pkg::CNT_W'(rlps_pkg::ROWS));

  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    pend_nxt   = pend_r;
    cmd        = '0;
    in_ready   = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            rlps_pkg::KIND_WRITE: begin
              cmd.wr_en = 1'b1;
            end
            rlps_pkg::KIND_CLEAR: begin
              cmd.clr_en = 1'b1;
            end
            rlps_pkg::KIND_TICK: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_row = '0;
              rd_cnt_nxt = rlps_pkg::CNT_W'(1);
              pend_nxt   = 1'b1;
              state_nxt  = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.load_row   = pend_r && status.slot_free;
        cmd.rd_en      = (!pend_r || status.slot_free) && !rows_done;
        cmd.rd_row     = rd_cnt_r[rlps_pkg::ROW_W-1:0];
        cmd.load_blank = !pend_r && rows_done && status.slot_free;
        if (cmd.rd_en) begin
          rd_cnt_nxt = rd_cnt_r + rlps_pkg::CNT_W'(1);
          pend_nxt   = 1'b1;
        end else if (cmd.load_row) begin
          pend_nxt = 1'b0;
        end
        if (cmd.load_blank) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_cnt_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rlps_datapath.sv
// Datapath of the scanner: per-column frame RAMs with valid bits, PWM counter,
// brightness register, row compare and the result register.
// Depends on rlps_pkg and rlps_ram.
`default_nettype none

module rlps_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rlps_pkg::dp_cmd_t            cmd,
  output rlps_pkg::dp_status_t              status,
  input  wire logic [rlps_pkg::IDX_W-1:0]   pixel_index,
  input  wire logic [rlps_pkg::LEVEL_W-1:0] red_level,
  input  wire logic [rlps_pkg::LEVEL_W-1:0] green_level,
  input  wire logic [rlps_pkg::LEVEL_W-1:0] blue_level,
  input  wire logic                         cfg_we,
  input  wire logic [rlps_pkg::LEVEL_W-1:0] cfg_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rlps_pkg::ROWS-1:0]         out_row_select,
  output logic [rlps_pkg::COLS-1:0]         out_green_bits,
  output logic [rlps_pkg::COLS-1:0]         out_red_bits,
  output logic [rlps_pkg::COLS-1:0]         out_blue_bits,
  output logic                              out_last
);

  logic [rlps_pkg::ROW_W-1:0]   wr_row;
  logic [rlps_pkg::COL_W-1:0]   wr_col;
  logic [rlps_pkg::PIXEL_W-1:0] wr_data;
  logic [rlps_pkg::PIXEL_W-1:0] rd_data [rlps_pkg::COLS];

  logic [rlps_pkg::COLS-1:0]    valid_r [rlps_pkg::ROWS];
  logic [rlps_pkg::COLS-1:0]    vmask_r;
  logic [rlps_pkg::ROW_W-1:0]   row_r;
  logic [rlps_pkg::LEVEL_W-1:0] pwm_r;
  logic [rlps_pkg::LEVEL_W-1:0] bright_r;

  logic                         out_valid_r;
  logic [rlps_pkg::ROWS-1:0]    row_sel_r;
  logic [rlps_pkg::COLS-1:0]    green_r, red_r, blue_r;
  logic                         last_r;

  logic [rlps_pkg::ROWS-1:0]    row_onehot;
  logic [rlps_pkg::COLS-1:0]    red_cmp, green_cmp, blue_cmp;
  logic                         slot_free;

  assign wr_row  = pixel_index[rlps_pkg::IDX_W-1 -: rlps_pkg::ROW_W];
  assign wr_col  = pixel_index[rlps_pkg::COL_W-1:0];
  assign wr_data = {blue_level, green_level, red_level};

  for (genvar c = 0; c < rlps_pkg::COLS; c++) begin : g_col
    rlps_ram #(
      .WIDTH(rlps_pkg::PIXEL_W),
      .DEPTH(rlps_pkg::ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (cmd.wr_en && (wr_col == rlps_pkg::COL_W'(c))),
      .waddr(wr_row),
      .wdata(wr_data),
      .re   (cmd.rd_en),
      .raddr(cmd.rd_row),
      .rdata(rd_data[c])
    );
  end

  // A pixel never written since reset or the last clear reads as zero.
  always_comb begin
    for (int c = 0; c < rlps_pkg::COLS; c++) begin
      logic [rlps_pkg::PIXEL_W-1:0] px;
      px = vmask_r[c] ? rd_data[c] : '0;
      red_cmp[c]   = (px[rlps_pkg::LEVEL_W-1:0] <= pwm_r);
      green_cmp[c] = (px[2*rlps_pkg::LEVEL_W-1 -: rlps_pkg::LEVEL_W] <= pwm_r);
      blue_cmp[c]  = (px[3*rlps_pkg::LEVEL_W-1 -: rlps_pkg::LEVEL_W] <= pwm_r);
    end
    for (int r = 0; r < rlps_pkg::ROWS; r++) begin
      row_onehot[r] = (row_r == rlps_pkg::ROW_W'(r));
    end
  end

  assign slot_free        = !out_valid_r || out_ready;
  assign status.slot_free = slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < rlps_pkg::ROWS; r++) begin
        valid_r[r] <= '0;
      end
    end else if (cmd.clr_en) begin
      for (int r = 0; r < rlps_pkg::ROWS; r++) begin
        valid_r[r] <= '0;
      end
    end else if (cmd.wr_en) begin
      valid_r[wr_row][wr_col] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      vmask_r <= valid_r[cmd.rd_row];
      row_r   <= cmd.rd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_r    <= '0;
      bright_r <= rlps_pkg::BRIGHT_RESET;
    end else begin
      if (cfg_we) begin
        bright_r <= cfg_data;
      end
      if (cmd.load_blank) begin
        pwm_r <= (pwm_r >= bright_r) ? '0 : pwm_r + rlps_pkg::LEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_row || cmd.load_blank) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      row_sel_r <= row_onehot;
      green_r   <= green_cmp;
      red_r     <= red_cmp;
      blue_r    <= blue_cmp;
      last_r    <= 1'b0;
    end else if (cmd.load_blank) begin
      row_sel_r <= rlps_pkg::BLANK_ROWS;
      green_r   <= rlps_pkg::BLANK_BITS;
      red_r     <= rlps_pkg::BLANK_BITS;
      blue_r    <= rlps_pkg::BLANK_BITS;
      last_r    <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_select = row_sel_r;
  assign out_green_bits = green_r;
  assign out_red_bits   = red_r;
  assign out_blue_bits  = blue_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

### hw/rtl/rgb_led_matrix_pwm_scanner_top.sv
// Write and clear items are taken while idle and leave the block ready. A tick
// reads one row per cycle through the RAM read-data and result registers, one
// result per cycle while the output is not stalled; it gives 9 results (one per
// row plus a blanking result) and no new item is taken until it ends.
// Reset (rst_n, synchronous): frame reads as all zero, PWM counter 0,
// brightness_top 255; there is no clearing pass.
// Top level of the scanner; depends on rlps_pkg, the channel interfaces,
// rlps_ctrl and rlps_datapath.
`default_nettype none

module rgb_led_matrix_pwm_scanner_top (
  input wire logic   clk,
  input wire logic   rst_n,
  rlps_in_if.sink    in_if,
  rlps_out_if.source out_if,
  rlps_cfg_if.sink   cfg_if
);

  rlps_pkg::dp_cmd_t    cmd;
  rlps_pkg::dp_status_t status;
  logic                 in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  rlps_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_if.valid),
    .in_kind (in_if.kind),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  rlps_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .pixel_index   (in_if.pixel_index),
    .red_level     (in_if.red_level),
    .green_level   (in_if.green_level),
    .blue_level    (in_if.blue_level),
    .cfg_we        (cfg_if.valid),
    .cfg_data      (cfg_if.brightness_top),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_row_select(out_if.row_select),
    .out_green_bits(out_if.green_bits),
    .out_red_bits  (out_if.red_bits),
    .out_blue_bits (out_if.blue_bits),
    .out_last      (out_if.last)
  );

endmodule

`default_nettype wire

### hw/rtl/rlps_checker.sv
// Port-level checks of the scanner, bound to the top level.
// Depends on rlps_pkg and rgb_led_matrix_pwm_scanner_top_defines.svh.
`default_nettype none
`include "rgb_led_matrix_pwm_scanner_top_defines.svh"

module rlps_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [rlps_pkg::KIND_W-1:0] in_kind,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [rlps_pkg::ROWS-1:0]   out_row_select,
  input wire logic                        out_last
);

  `RLPS_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && in_kind == rlps_pkg::KIND_TICK, !in_ready, "input taken during a tick")
  `RLPS_ASSERT_SAME(a_row_onehot, out_valid && !out_last, $onehot(out_row_select), "row result without one-hot row select")
  `RLPS_ASSERT_SAME(a_blank_rows, out_valid && out_last, out_row_select == rlps_pkg::BLANK_ROWS, "blanking result with a row selected")
  `RLPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_row_select) && $stable(out_last), "stalled result changed")

endmodule

bind rgb_led_matrix_pwm_scanner_top rlps_checker u_rlps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_kind       (in_if.kind),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_row_select(out_if.row_select),
  .out_last      (out_if.last)
);

`default_nettype wire
